// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define SSFH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sensor_sample_fold_hash assertion failed");

// Checked at every rising clock edge, reset included.
`define SSFH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("sensor_sample_fold_hash assertion failed");

`endif

// File: sv/ssfh_pkg.sv
// Package with constants, types and hash functions of the sample fold hash block.
`default_nettype none

package ssfh_pkg;

    localparam int unsigned SAMPLE_COUNT_DEF = 11;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned HASH_W   = 16;
    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned SPAN_W   = VALUE_W + 1;

    localparam logic [HASH_W-1:0] SAMPLE_SEED = 16'h0B11;
    localparam logic [HASH_W-1:0] DELTA_SEED  = 16'hB10C;
    localparam logic [HASH_W-1:0] NAME_SEED   = 16'h0C11;

    localparam logic [VALUE_W-1:0] MIN_RESET = 8'd1;
    localparam logic [VALUE_W-1:0] MAX_RESET = 8'd20;

    localparam int unsigned DELTA_ROT = 5;
    localparam int unsigned NAME_ROT  = 9;
    localparam int unsigned FOLD_A    = 8;
    localparam int unsigned FOLD_B    = 4;
    localparam int unsigned FOLD_C    = 11;

    localparam int unsigned DIV_STEPS = HASH_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_NAME_HASH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_VALUE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE = 2'd2;

    typedef struct packed {
        logic acc_en;
        logic first;
        logic fold;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    function automatic logic [HASH_W-1:0] rotl5(input logic [HASH_W-1:0] v);
        rotl5 = {v[HASH_W-1-DELTA_ROT:0], v[HASH_W-1:HASH_W-DELTA_ROT]};
    endfunction

    function automatic logic [HASH_W-1:0] rotl9(input logic [HASH_W-1:0] v);
        rotl9 = {v[HASH_W-1-NAME_ROT:0], v[HASH_W-1:HASH_W-NAME_ROT]};
    endfunction

    function automatic logic [HASH_W-1:0] fold_hash(input logic [HASH_W-1:0] v);
        logic [HASH_W-1:0] c;
        c = v;
        c = c ^ (c >> FOLD_A);
        c = c ^ (c >> FOLD_B);
        c = c ^ (c >> FOLD_C);
        fold_hash = c;
    endfunction

endpackage

`default_nettype wire

// File: sv/ssfh_ctrl.sv
// Controller state machine that sequences accumulation, folding, reduction and output.
`default_nettype none

module ssfh_ctrl #(
    parameter int unsigned SAMPLE_COUNT = ssfh_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output ssfh_pkg::t_dp_cmd     o_cmd
);
    import ssfh_pkg::*;

    localparam int unsigned CNT_W = $clog2(SAMPLE_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FOLD,
        S_DIV,
        S_OUT
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_seen, n_seen;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  w_accept;
    logic                  w_last;
    logic                  w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_last     = (r_seen == CNT_W'(SAMPLE_COUNT - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.first = (r_seen == '0);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.acc_en = 1'b1;
                    if (w_last) begin
                        n_seen  = '0;
                        n_state = S_FOLD;
                    end else begin
                        n_seen = r_seen + CNT_W'(1);
                    end
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_cnt      = DIV_CNT_W'(DIV_STEPS - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: sv/ssfh_dp.sv
// Datapath with the two Horner accumulators, the fold and the bit-serial range reduction.
`default_nettype none

module ssfh_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ssfh_pkg::t_dp_cmd              i_cmd,
    input  wire logic [ssfh_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic [ssfh_pkg::HASH_W-1:0]    i_name_hash,
    input  wire logic [ssfh_pkg::VALUE_W-1:0]   i_min_value,
    input  wire logic [ssfh_pkg::VALUE_W-1:0]   i_max_value,
    output logic [ssfh_pkg::VALUE_W-1:0]        o_result_value
);
    import ssfh_pkg::*;

    logic [HASH_W-1:0]   r_sample_acc;
    logic [HASH_W-1:0]   r_delta_acc;
    logic [SAMPLE_W-1:0] r_prev;
    logic [HASH_W-1:0]   r_c;
    logic [SPAN_W-1:0]   r_span;
    logic                r_inv;
    logic [VALUE_W-1:0]  r_rem;
    logic [VALUE_W-1:0]  r_result;

    logic [SAMPLE_W-1:0] w_delta;
    logic [HASH_W-1:0]   w_sample_next;
    logic [HASH_W-1:0]   w_delta_next;
    logic [HASH_W-1:0]   w_mix;
    logic [SPAN_W-1:0]   w_trial;
    logic [SPAN_W-1:0]   w_sum;
    logic [VALUE_W-1:0]  w_value;

    always_comb begin
        if (i_cmd.first) begin
            w_delta = '0;
        end else if (i_sample > r_prev) begin
            w_delta = i_sample - r_prev;
        end else begin
            w_delta = r_prev - i_sample;
        end
    end

    // Multiplying by 257 is the value plus itself shifted by one byte.
    assign w_sample_next = r_sample_acc + (r_sample_acc << 8) + HASH_W'(i_sample);
    assign w_delta_next  = r_delta_acc + (r_delta_acc << 8) + HASH_W'(w_delta);

    assign w_mix = fold_hash(r_sample_acc ^ rotl5(r_delta_acc) ^ rotl9(i_name_hash));

    assign w_trial = {r_rem, r_c[HASH_W-1]};

    assign w_sum = SPAN_W'(i_min_value) + SPAN_W'(r_rem);

    always_comb begin
        if (r_inv) begin
            w_value = i_max_value;
        end else if (w_sum > SPAN_W'(i_max_value)) begin
            w_value = i_max_value;
        end else begin
            w_value = w_sum[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_acc <= SAMPLE_SEED;
            r_delta_acc  <= DELTA_SEED;
            r_prev       <= '0;
        end else if (i_cmd.acc_en) begin
            r_sample_acc <= w_sample_next;
            r_delta_acc  <= w_delta_next;
            r_prev       <= i_sample;
        end else if (i_cmd.fold) begin
            r_sample_acc <= SAMPLE_SEED;
            r_delta_acc  <= DELTA_SEED;
            r_prev       <= '0;
        end
        if (i_cmd.fold) begin
            r_c    <= w_mix;
            r_span <= SPAN_W'(i_max_value) - SPAN_W'(i_min_value) + SPAN_W'(1);
            r_inv  <= (i_max_value < i_min_value);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_c <= r_c << 1;
            if (w_trial >= r_span) begin
                r_rem <= VALUE_W'(w_trial - r_span);
            end else begin
                r_rem <= w_trial[VALUE_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_result <= w_value;
        end
    end

    assign o_result_value = r_result;

endmodule

`default_nettype wire

// File: sv/sensor_sample_fold_hash.sv
// Top level of the sample fold hash block with its register port.
// Samples before the last of a run go back to back.
// The last sample of a run stalls the input through the fold state, the steps of the bit-serial
// remainder unit and the output state, longer if the output is stalled.
// The result valid is registered and rises when the output state loads the result.
// Synchronous active-low reset restores the accumulators, registers and output valid.
`default_nettype none

module sensor_sample_fold_hash #(
    parameter int unsigned SAMPLE_COUNT = ssfh_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [ssfh_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [ssfh_pkg::VALUE_W-1:0]          o_result_value,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ssfh_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ssfh_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ssfh_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import ssfh_pkg::*;

    logic [HASH_W-1:0]    r_name_hash;
    logic [VALUE_W-1:0]   r_min_value;
    logic [VALUE_W-1:0]   r_max_value;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_write;
    t_dp_cmd              w_cmd;

    assign pready  = 1'b1;
    assign w_idx   = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_hash <= NAME_SEED;
            r_min_value <= MIN_RESET;
            r_max_value <= MAX_RESET;
        end else if (w_write) begin
            case (w_idx)
                REG_NAME_HASH: r_name_hash <= pwdata[HASH_W-1:0];
                REG_MIN_VALUE: r_min_value <= pwdata[VALUE_W-1:0];
                REG_MAX_VALUE: r_max_value <= pwdata[VALUE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NAME_HASH: prdata = APB_DATA_W'(r_name_hash);
            REG_MIN_VALUE: prdata = APB_DATA_W'(r_min_value);
            REG_MAX_VALUE: prdata = APB_DATA_W'(r_max_value);
            default:       prdata = '0;
        endcase
    end

    ssfh_ctrl #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    ssfh_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_sample       (i_sample),
        .i_name_hash    (r_name_hash),
        .i_min_value    (r_min_value),
        .i_max_value    (r_max_value),
        .o_result_value (o_result_value)
    );

endmodule

`default_nettype wire

// File: sv/ssfh_checker.sv
// Port-level checker of the sample fold hash block and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module ssfh_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [ssfh_pkg::VALUE_W-1:0]  o_result_value
);

    `SSFH_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)

    `SSFH_ASSERT(a_out_holds, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value))

    `SSFH_ASSERT(a_stall_after_beat, i_clk, i_rst_n,
        $rose(o_in_stall) |-> $past(i_in_valid))

    `SSFH_ASSERT(a_result_after_busy, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(o_in_stall))

endmodule

bind sensor_sample_fold_hash ssfh_checker u_ssfh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value)
);

`default_nettype wire

// File: test/sensor_sample_fold_hash_tb.sv
// Self-checking testbench for the sensor sample fold hash block.
`default_nettype none

module sensor_sample_fold_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LEN        = ssfh_pkg::SAMPLE_COUNT_DEF;
    localparam int unsigned RANDOM_ITEMS   = 1000;
    localparam int unsigned MAX_WAIT       = 17;
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;

    localparam int unsigned HORNER_BASE  = 257;
    localparam int unsigned DELTA_TWIST  = 5;
    localparam int unsigned NAME_TWIST   = 9;
    localparam logic [15:0] SAMPLE_START = 16'h0B11;
    localparam logic [15:0] DELTA_START  = 16'hB10C;
    localparam logic [15:0] NAME_START   = 16'h0C11;
    localparam logic [7:0]  LOW_START    = 8'd1;
    localparam logic [7:0]  HIGH_START   = 8'd20;

    localparam logic [ssfh_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [9:0] OPENING [22] = '{
        10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023,
        10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0,
        10'd1023, 10'd1023, 10'd1023, 10'd512, 10'd511,
        10'd1, 10'd0, 10'd0, 10'd1023, 10'd341, 10'd682
    };

    class hash_scoreboard;
        logic [15:0] name_hash;
        logic [7:0]  low_bound;
        logic [7:0]  high_bound;
        logic [15:0] sample_acc;
        logic [15:0] delta_acc;
        logic [9:0]  last_sample;
        int unsigned run_pos;
        logic [7:0]  expected_values[$];
        int unsigned mismatches;

        function new();
            name_hash  = NAME_START;
            low_bound  = LOW_START;
            high_bound = HIGH_START;
            mismatches = 0;
            clear_run();
        endfunction

        function void clear_run();
            sample_acc  = SAMPLE_START;
            delta_acc   = DELTA_START;
            last_sample = '0;
            run_pos     = 0;
        endfunction

        function logic [15:0] rotl16(logic [15:0] v, int unsigned k);
            return (v << k) | (v >> (16 - k));
        endfunction

        function logic [7:0] reduce_run();
            logic [15:0] c;
            int unsigned span;
            int unsigned v;
            c = sample_acc ^ rotl16(delta_acc, DELTA_TWIST) ^ rotl16(name_hash, NAME_TWIST);
            c = c ^ (c >> 8);
            c = c ^ (c >> 4);
            c = c ^ (c >> 11);
            if (high_bound < low_bound) begin
                return high_bound;
            end
            span = int'(high_bound) - int'(low_bound) + 1;
            v = int'(low_bound) + (int'(c) % span);
            if (v > int'(high_bound)) begin
                v = int'(high_bound);
            end
            return v[7:0];
        endfunction

        function void take_sample(logic [9:0] s);
            logic [15:0] diff;
            if (run_pos == 0) begin
                diff = '0;
            end else if (s > last_sample) begin
                diff = 16'(s - last_sample);
            end else begin
                diff = 16'(last_sample - s);
            end
            sample_acc  = 16'(sample_acc * HORNER_BASE + s);
            delta_acc   = 16'(delta_acc * HORNER_BASE + diff);
            last_sample = s;
            run_pos++;
            if (run_pos >= RUN_LEN) begin
                expected_values.push_back(reduce_run());
                clear_run();
            end
        endfunction

        function void set_reg(logic [ssfh_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                ssfh_pkg::REG_NAME_HASH: name_hash = val[15:0];
                ssfh_pkg::REG_MIN_VALUE: low_bound = val[7:0];
                ssfh_pkg::REG_MAX_VALUE: high_bound = val[7:0];
                default: ;
            endcase
        endfunction

        function void report(string what, logic [31:0] exp, logic [31:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%s mismatch: expected %0d, got %0d", what, exp, got);
            end
        endfunction

        function void check_value(logic [7:0] got);
            logic [7:0] exp;
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result_value %0d arrived with nothing expected", got);
                end
                return;
            end
            exp = expected_values.pop_front();
            if (got !== exp) begin
                report("result_value", exp, got);
            end
        endfunction

        function void check_reg(logic [ssfh_pkg::REG_IDX_W-1:0] idx, logic [31:0] got);
            logic [31:0] exp;
            case (idx)
                ssfh_pkg::REG_NAME_HASH: exp = {16'd0, name_hash};
                ssfh_pkg::REG_MIN_VALUE: exp = {24'd0, low_bound};
                default: exp = {24'd0, high_bound};
            endcase
            if (got !== exp) begin
                report("register read", exp, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [ssfh_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [ssfh_pkg::VALUE_W-1:0] o_result_value;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ssfh_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ssfh_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ssfh_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    hash_scoreboard sb = new();
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    sensor_sample_fold_hash #(
        .SAMPLE_COUNT(RUN_LEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sample(i_sample),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_result_value(o_result_value),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [9:0] pick_sample(logic [9:0] prev);
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1023;
            2: return prev;
            3, 4: return 10'(int'(prev) + int'($urandom_range(0, 14)) - 7);
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_value(o_result_value);
                stall_left = draw_wait(out_calm);
                i_out_stall <= (stall_left != 0);
            end else if (o_out_valid && stall_left != 0) begin
                stall_left--;
                i_out_stall <= (stall_left != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_sample(input logic [9:0] s);
        int unsigned gap;
        gap = draw_wait(in_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_sample(s);
    endtask

    task automatic apb_access(input bit wr, input logic [ssfh_pkg::REG_IDX_W-1:0] idx,
                              input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ssfh_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) begin
            sb.set_reg(idx, val);
        end else begin
            sb.check_reg(idx, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_back();
        apb_access(1'b0, ssfh_pkg::REG_NAME_HASH, '0);
        apb_access(1'b0, ssfh_pkg::REG_MIN_VALUE, '0);
        apb_access(1'b0, ssfh_pkg::REG_MAX_VALUE, '0);
    endtask

    task automatic configure(input logic [15:0] name, input logic [7:0] lo,
                             input logic [7:0] hi);
        apb_access(1'b1, ssfh_pkg::REG_NAME_HASH, {16'($urandom), name});
        apb_access(1'b1, ssfh_pkg::REG_MIN_VALUE, {24'($urandom), lo});
        apb_access(1'b1, ssfh_pkg::REG_MAX_VALUE, {24'($urandom), hi});
        apb_access(1'b1, REG_SPARE, $urandom);
        read_back();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned phase;
        int unsigned burst;
        logic [9:0] prev;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] tmp;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back();

        foreach (OPENING[i]) begin
            send_sample(OPENING[i]);
        end
        drain();

        sent  = 0;
        phase = 0;
        prev  = '0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: configure(16'hFFFF, 8'd0, 8'd255);
                1: configure(16'h0000, 8'd200, 8'd10);
                2: configure($urandom, 8'd255, 8'd255);
                3: configure(16'h0000, 8'd0, 8'd0);
                4: configure($urandom, 8'd0, 8'd1);
                default: begin
                    lo = $urandom_range(0, 255);
                    hi = $urandom_range(0, 255);
                    if (lo > hi && $urandom_range(0, 3) != 0) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    configure($urandom, lo, hi);
                end
            endcase
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(80, 140);
            repeat (burst) begin
                prev = pick_sample(prev);
                send_sample(prev);
                sent++;
            end
            drain();
            phase++;
        end

        drain();
        if (sb.mismatches == 0 && sb.expected_values.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
